// ===== rtl/core/btt_pkg.sv =====
// Package for the bucketed transposition table unit.
// Holds the payload structs, command/status structs, codes and field constants.
// Depends on nothing; every other file of the block but btt_ram imports it.
`default_nettype none

package btt_pkg;

   // Fixed field widths.
   localparam int KeyWidth   = 64;
   localparam int FlagWidth  = 15;
   localparam int FillWidth  = 13;
   localparam int FillLimit  = 8191;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 32;

   // Default configuration of the table.
   localparam int DefBuckets = 1024;
   localparam int DefWays    = 4;

   // Request kinds.
   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Bound code that marks an exact score.
   localparam logic [1:0] BOUND_EXACT = 2'd1;

   // Slack allowed before a deeper same-key entry blocks a store.
   localparam int DepthSlack = 3;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_CURRENT_AGE  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MATE_BOUND   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_NO_MOVE_CODE = 2'd2;

   // Reset value of the mate bound configuration register.
   localparam logic [14:0] MATE_BOUND_RESET = 15'd30000;

   // Input item.
   typedef struct packed {
      logic [1:0]         kind;
      logic [63:0]        key;
      logic [6:0]         ply;
      logic signed [7:0]  search_depth;
      logic signed [15:0] score_in;
      logic signed [15:0] eval_in;
      logic [1:0]         bound_in;
      logic [31:0]        move_in;
   } btt_req_type;

   // Result item.
   typedef struct packed {
      logic               hit;
      logic signed [15:0] score_out;
      logic signed [15:0] eval_out;
      logic [31:0]        move_out;
      logic [14:0]        entry_flags;
      logic [12:0]        fill_count;
   } btt_rsp_type;

   // One table entry as held in memory.
   typedef struct packed {
      logic [63:0] key;
      logic [14:0] flags;
      logic [15:0] score;
      logic [15:0] eval;
      logic [31:0] move;
   } btt_entry_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_MOD,
      ST_READ,
      ST_EVAL,
      ST_WRITE,
      ST_WIPE,
      ST_RESP
   } btt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mod_step;
      logic eval;
      logic write;
      logic wipe;
      logic rsp_load;
   } btt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       mod_done;
      logic       scan_done;
      logic       wipe_done;
      logic       rsp_free;
   } btt_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/btt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module btt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire                                     clock,
   input  wire                                     we,
   input  wire  [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
   input  wire  [Width-1:0]                        wdata,
   input  wire  [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
   output logic [Width-1:0]                        rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/btt_ctrl.sv =====
// Controller state machine of the transposition table unit.
// Depends on btt_pkg for the state, command and status types.
`default_nettype none

module btt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  btt_pkg::btt_sts_type sts,
   output btt_pkg::btt_cmd_type cmd
);
   import btt_pkg::*;

   btt_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.kind)
               KIND_PROBE, KIND_STORE: state_in = ST_MOD;
               KIND_CLEAR:             state_in = ST_WIPE;
               default:                state_in = ST_RESP;
            endcase
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_READ;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (!sts.scan_done) begin
               state_in = ST_READ;
            end else if (sts.kind == KIND_STORE) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_RESP;
         end
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // The controller never issues two memory-changing commands at once.
   assert property (@(posedge clock) disable iff (reset) !(cmd.write && cmd.wipe))
      else $error("write and wipe issued together");
   // A write always follows the final way evaluation of a store.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> $past(cmd.eval && sts.scan_done))
      else $error("write without completed scan");
   // A new request is only taken once the previous response was loaded.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(cmd.rsp_load || state_ff == ST_IDLE || state_ff == ST_INIT))
      else $error("load while busy");

endmodule

`default_nettype wire

// ===== rtl/core/btt_datapath.sv =====
// Datapath of the transposition table unit: request and config registers,
// bucket index unit, way scan, entry write, clear sweep and response register.
// Depends on btt_pkg and btt_ram.
`default_nettype none

module btt_datapath #(
   parameter int Buckets = btt_pkg::DefBuckets,
   parameter int Ways    = btt_pkg::DefWays
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  btt_pkg::btt_req_type                      req_data,
   output btt_pkg::btt_rsp_type                      rsp_data,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready,
   input  wire                                       csr_we,
   input  wire  [btt_pkg::CsrIdxWidth-1:0]           csr_index,
   input  wire  [btt_pkg::CsrDataWidth-1:0]          csr_wdata,
   input  btt_pkg::btt_cmd_type                      cmd,
   output btt_pkg::btt_sts_type                      sts
);
   import btt_pkg::*;

   localparam int Total     = Buckets * Ways;
   localparam int AddrWidth = Total > 1 ? $clog2(Total) : 1;
   localparam int BktWidth  = Buckets > 1 ? $clog2(Buckets) : 1;
   localparam int WayWidth  = Ways > 1 ? $clog2(Ways) : 1;
   localparam int FillCap   = Total < FillLimit ? Total : FillLimit;
   localparam int EntryWidth = $bits(btt_entry_type);

   // Captured request and configuration.
   btt_req_type req_ff;
   logic [6:0]  age_ff;
   logic [14:0] mate_ff;
   logic [31:0] nomove_ff;
   logic [31:0] wipe_move_ff;

   // Scan state.
   logic [BktWidth-1:0]  rem;
   logic [WayWidth-1:0]  way_ff;
   logic [WayWidth-1:0]  chosen_ff;
   logic                 have_ff;
   logic                 same_ff;
   logic [31:0]          old_move_ff;
   logic [14:0]          old_flags_ff;
   logic                 hit_ff;
   btt_entry_type        hit_entry_ff;
   logic [FillWidth-1:0] occ_ff;
   logic [AddrWidth-1:0] wipe_cnt_ff;
   btt_rsp_type          rsp_ff;
   logic                 rsp_valid_ff;
   logic                 mod_done;

   // Bucket index: key modulo the bucket count.
   if (Buckets == 1) begin : g_one_bucket
      assign rem      = '0;
      assign mod_done = 1'b1;
   end else if ((Buckets & (Buckets - 1)) == 0) begin : g_pow2
      assign rem      = req_ff.key[BktWidth-1:0];
      assign mod_done = 1'b1;
   end else begin : g_iter
      // Four key bits a cycle, most significant first, each a shift and a
      // conditional subtract of the bucket count.
      logic [BktWidth-1:0] rem_ff;
      logic [KeyWidth-1:0] shift_ff;
      logic [4:0]          cnt_ff;
      logic [BktWidth:0]   r_next;
      always_comb begin
         r_next = {1'b0, rem_ff};
         for (int i = 0; i < 4; i++) begin
            r_next = {r_next[BktWidth-1:0], shift_ff[KeyWidth-1-i]};
            if (r_next >= (BktWidth+1)'(Buckets)) begin
               r_next = r_next - (BktWidth+1)'(Buckets);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff <= '0;
         end else if (cmd.load) begin
            cnt_ff   <= '0;
            rem_ff   <= '0;
            shift_ff <= req_data.key;
         end else if (cmd.mod_step) begin
            cnt_ff   <= cnt_ff + 5'd1;
            rem_ff   <= r_next[BktWidth-1:0];
            shift_ff <= {shift_ff[KeyWidth-5:0], 4'd0};
         end
      end
      assign rem      = rem_ff;
      assign mod_done = (cnt_ff == 5'd16);
   end

   // Addresses of the current and the chosen way.
   logic [AddrWidth-1:0] base;
   logic [AddrWidth-1:0] raddr;
   logic [AddrWidth-1:0] waddr;
   assign base  = AddrWidth'(rem) * AddrWidth'(Ways);
   assign raddr = base + AddrWidth'(way_ff);

   btt_entry_type rd_entry;
   btt_entry_type wr_entry;
   logic          ram_we;
   logic [EntryWidth-1:0] rdata_raw;

   btt_ram #(
      .Width (EntryWidth),
      .Depth (Total)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (wr_entry),
      .raddr (raddr),
      .rdata (rdata_raw)
   );
   assign rd_entry = btt_entry_type'(rdata_raw);

   // Way evaluation.
   logic last_way;
   logic key_eq;
   logic key_empty;
   logic age_eq;
   logic shallow;
   logic scan_done;
   logic bump;
   assign last_way  = (way_ff == WayWidth'(Ways - 1));
   assign key_eq    = (rd_entry.key == req_ff.key);
   assign key_empty = (rd_entry.key == '0);
   assign age_eq    = (rd_entry.flags[6:0] == age_ff);
   assign shallow   = $signed({3'b000, rd_entry.flags[12:7]})
                      < $signed({req_ff.search_depth[7], req_ff.search_depth});

   always_comb begin
      scan_done = last_way;
      bump      = 1'b0;
      if (req_ff.kind == KIND_PROBE) begin
         if (key_eq && age_eq) begin
            scan_done = 1'b1;
         end
      end else if (key_eq || key_empty) begin
         scan_done = 1'b1;
         bump      = !key_eq;
      end else begin
         bump = !age_eq;
      end
   end

   // Store values: skip test, mate adjustment, depth clamp and move choice.
   logic               skip;
   logic signed [17:0] score_wide;
   logic signed [17:0] mate_wide;
   logic signed [17:0] score_adj;
   logic [15:0]        score_sat;
   logic [5:0]         depth_clamp;
   logic [31:0]        move_sel;
   assign skip = same_ff && (old_flags_ff[14:13] != BOUND_EXACT)
                 && ($signed({{2{req_ff.search_depth[7]}}, req_ff.search_depth})
                     < $signed({4'b0000, old_flags_ff[12:7]}) - 10'sd3);
   assign score_wide = 18'(req_ff.score_in);
   assign mate_wide  = $signed({3'b000, mate_ff});

   always_comb begin
      if (score_wide >= mate_wide) begin
         score_adj = score_wide + $signed({11'd0, req_ff.ply});
      end else if (score_wide <= -mate_wide) begin
         score_adj = score_wide - $signed({11'd0, req_ff.ply});
      end else begin
         score_adj = score_wide;
      end
      if (score_adj > 18'sd32767) begin
         score_sat = 16'h7FFF;
      end else if (score_adj < -18'sd32768) begin
         score_sat = 16'h8000;
      end else begin
         score_sat = score_adj[15:0];
      end
      if (req_ff.search_depth[7]) begin
         depth_clamp = 6'd0;
      end else if (req_ff.search_depth > 8'sd63) begin
         depth_clamp = 6'd63;
      end else begin
         depth_clamp = req_ff.search_depth[5:0];
      end
      move_sel = (same_ff && req_ff.move_in == nomove_ff) ? old_move_ff : req_ff.move_in;
   end

   // Memory write: clear sweep or store.
   always_comb begin
      if (cmd.wipe) begin
         ram_we        = 1'b1;
         waddr         = wipe_cnt_ff;
         wr_entry      = '0;
         wr_entry.move = wipe_move_ff;
      end else begin
         ram_we         = cmd.write && !skip;
         waddr          = base + AddrWidth'(chosen_ff);
         wr_entry.key   = req_ff.key;
         wr_entry.flags = {req_ff.bound_in, depth_clamp, age_ff};
         wr_entry.score = score_sat;
         wr_entry.eval  = req_ff.eval_in;
         wr_entry.move  = move_sel;
      end
   end

   // Request, configuration and scan registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff       <= '0;
         mate_ff      <= MATE_BOUND_RESET;
         nomove_ff    <= '0;
         wipe_move_ff <= '0;
         occ_ff       <= '0;
         wipe_cnt_ff  <= '0;
         hit_ff       <= 1'b0;
         have_ff      <= 1'b0;
         way_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CURRENT_AGE:  age_ff    <= csr_wdata[6:0];
               CSR_MATE_BOUND:   mate_ff   <= csr_wdata[14:0];
               CSR_NO_MOVE_CODE: nomove_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            req_ff  <= req_data;
            way_ff  <= '0;
            hit_ff  <= 1'b0;
            have_ff <= 1'b0;
            same_ff <= 1'b0;
            if (req_data.kind == KIND_CLEAR) begin
               age_ff       <= '0;
               wipe_move_ff <= nomove_ff;
               wipe_cnt_ff  <= '0;
               occ_ff       <= '0;
            end
         end
         if (cmd.eval) begin
            if (!scan_done) begin
               way_ff <= way_ff + WayWidth'(1);
            end
            if (bump && occ_ff < FillWidth'(FillCap)) begin
               occ_ff <= occ_ff + FillWidth'(1);
            end
            if (req_ff.kind == KIND_PROBE) begin
               if (key_eq && age_eq) begin
                  hit_ff       <= 1'b1;
                  hit_entry_ff <= rd_entry;
               end
            end else if (key_eq) begin
               chosen_ff    <= way_ff;
               have_ff      <= 1'b1;
               same_ff      <= 1'b1;
               old_move_ff  <= rd_entry.move;
               old_flags_ff <= rd_entry.flags;
            end else if (key_empty || !age_eq || shallow || (last_way && !have_ff)) begin
               chosen_ff <= way_ff;
               have_ff   <= 1'b1;
            end
         end
         if (cmd.wipe) begin
            if (wipe_cnt_ff == AddrWidth'(Total - 1)) begin
               wipe_cnt_ff <= '0;
            end else begin
               wipe_cnt_ff <= wipe_cnt_ff + AddrWidth'(1);
            end
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.hit         <= hit_ff;
         rsp_ff.score_out   <= hit_ff ? hit_entry_ff.score : 16'd0;
         rsp_ff.eval_out    <= hit_ff ? hit_entry_ff.eval  : 16'd0;
         rsp_ff.move_out    <= hit_ff ? hit_entry_ff.move  : nomove_ff;
         rsp_ff.entry_flags <= hit_ff ? hit_entry_ff.flags : 15'd0;
         rsp_ff.fill_count  <= occ_ff;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign sts.kind      = req_ff.kind;
   assign sts.mod_done  = mod_done;
   assign sts.scan_done = scan_done;
   assign sts.wipe_done = (wipe_cnt_ff == AddrWidth'(Total - 1));
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Occupancy never passes its cap.
   assert property (@(posedge clock) disable iff (reset) occ_ff <= FillWidth'(FillCap))
      else $error("fill count beyond cap");
   // A store always has a way chosen by the time it writes.
   assert property (@(posedge clock) disable iff (reset) cmd.write |-> have_ff)
      else $error("store write without chosen way");
   // The clear sweep restarts at entry zero once it has finished.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.wipe && sts.wipe_done) |-> wipe_cnt_ff == '0)
      else $error("clear sweep did not wrap");

endmodule

`default_nettype wire

// ===== rtl/core/bucketed_transposition_table_unit.sv =====
// Top level of the bucketed transposition table unit.
// Depends on btt_pkg, btt_ctrl and btt_datapath (which holds btt_ram).
//
// Set-associative table of Buckets x Ways entries keyed by a 64-bit hash;
// one request at a time, one response per request. After reset the unit
// sweeps the entry memory, one entry a cycle, before it takes a request;
// config writes are taken throughout. A probe or store examines the ways
// of its bucket in turn, one memory read and then one compare per way, and
// a store then writes the chosen way unless a deeper entry is kept; when
// Buckets is not a power of two the bucket index unit first works through
// the key four bits a cycle. A clear sweeps every entry of the memory.
`default_nettype none

module bucketed_transposition_table_unit #(
   parameter int Buckets = btt_pkg::DefBuckets,
   parameter int Ways    = btt_pkg::DefWays
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  btt_pkg::btt_req_type              req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output btt_pkg::btt_rsp_type              rsp_data,
   input  wire                               csr_we,
   input  wire  [btt_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire  [btt_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import btt_pkg::*;

   btt_cmd_type cmd;
   btt_sts_type sts;

   btt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   btt_datapath #(
      .Buckets (Buckets),
      .Ways    (Ways)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== dv/btt_scoreboard.sv =====
// Scoreboard for the bucketed transposition table unit: predicts each response
// from its own copy of the table and registers, and compares accepted responses.
// Depends on btt_pkg for the payload types and codes.
`default_nettype none

module btt_scoreboard (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_ready,
   input  btt_pkg::btt_req_type              req_data,
   input  wire                               rsp_valid,
   input  wire                               rsp_ready,
   input  btt_pkg::btt_rsp_type              rsp_data,
   input  wire                               csr_we,
   input  wire  [btt_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire  [btt_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                errors,
   output int                                pending
);
   import btt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumBuckets = DefBuckets;
   localparam int NumWays    = DefWays;
   localparam int NumEntries = NumBuckets * NumWays;
   localparam int OccCap     = (NumEntries < FillLimit) ? NumEntries : FillLimit;

   // Shadow copy of the table and registers.
   logic [63:0] tbl_key   [NumEntries];
   logic [14:0] tbl_flags [NumEntries];
   logic [15:0] tbl_score [NumEntries];
   logic [15:0] tbl_eval  [NumEntries];
   logic [31:0] tbl_move  [NumEntries];
   int          occupied;
   logic [6:0]  age_now;
   logic [14:0] mate_lim;
   logic [31:0] empty_move;

   btt_rsp_type answers_due[$];

   initial begin
      errors = 0;
   end

   assign pending = answers_due.size();

   // Empties every entry and the occupancy count.
   task automatic wipe_shadow();
      for (int i = 0; i < NumEntries; i++) begin
         tbl_key[i]   = '0;
         tbl_flags[i] = '0;
         tbl_score[i] = '0;
         tbl_eval[i]  = '0;
         tbl_move[i]  = empty_move;
      end
      occupied = 0;
   endtask

   task automatic bump_occupied();
      if (occupied < OccCap) occupied++;
   endtask

   // Replacement choice and write for one store.
   task automatic apply_store(input btt_req_type r);
      int          base;
      int          pick;
      int          e;
      int          depth;
      int          score;
      int          mb;
      int          dclamp;
      logic [31:0] mv;
      base  = int'(r.key % NumBuckets) * NumWays;
      pick  = -1;
      depth = int'($signed(r.search_depth));
      mv    = r.move_in;
      for (int w = 0; w < NumWays; w++) begin
         e = base + w;
         if (tbl_key[e] == r.key) begin
            pick = w;
            if (mv == empty_move) mv = tbl_move[e];
            break;
         end else if (tbl_key[e] == '0) begin
            bump_occupied();
            pick = w;
            break;
         end else begin
            if (tbl_flags[e][6:0] != age_now) begin
               bump_occupied();
               pick = w;
            end
            if (int'(tbl_flags[e][12:7]) < depth) pick = w;
         end
      end
      if (pick < 0) pick = NumWays - 1;
      e = base + pick;

      // A non-exact entry of the same position deeper by more than DepthSlack is kept.
      if (tbl_flags[e][14:13] != BOUND_EXACT && tbl_key[e] == r.key &&
          depth < int'(tbl_flags[e][12:7]) - DepthSlack)
         return;

      // Mate scores move away from zero by the ply distance.
      score = int'($signed(r.score_in));
      mb    = int'(mate_lim);
      if (score >= mb) score += int'(r.ply);
      else if (score <= -mb) score -= int'(r.ply);
      if (score > 32767) score = 32767;
      if (score < -32768) score = -32768;

      dclamp = (depth > 63) ? 63 : (depth < 0) ? 0 : depth;
      tbl_key[e]   = r.key;
      tbl_flags[e] = {r.bound_in, 6'(dclamp), age_now};
      tbl_score[e] = 16'(score);
      tbl_eval[e]  = r.eval_in;
      tbl_move[e]  = mv;
   endtask

   // Works out the response that one request produces.
   task automatic predict_answer(input btt_req_type r);
      btt_rsp_type a;
      int          base;
      a = '0;
      a.move_out = empty_move;
      base = int'(r.key % NumBuckets) * NumWays;
      case (r.kind)
         KIND_PROBE: begin
            for (int w = 0; w < NumWays; w++) begin
               if (tbl_key[base + w] == r.key && tbl_flags[base + w][6:0] == age_now) begin
                  a.hit         = 1'b1;
                  a.score_out   = tbl_score[base + w];
                  a.eval_out    = tbl_eval[base + w];
                  a.move_out    = tbl_move[base + w];
                  a.entry_flags = tbl_flags[base + w];
                  break;
               end
            end
         end
         KIND_STORE: apply_store(r);
         KIND_CLEAR: begin
            wipe_shadow();
            age_now = '0;
         end
         default: ;
      endcase
      a.fill_count = 13'(occupied);
      answers_due.push_back(a);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: response %s is 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
   endtask

   // Register writes, request transfers and response transfers at each edge.
   always @(posedge clock) begin
      btt_rsp_type want;
      if (reset) begin
         age_now    = '0;
         mate_lim   = MATE_BOUND_RESET;
         empty_move = '0;
         wipe_shadow();
         answers_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CURRENT_AGE:  age_now    = csr_wdata[6:0];
               CSR_MATE_BOUND:   mate_lim   = csr_wdata[14:0];
               CSR_NO_MOVE_CODE: empty_move = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response transfer with nothing outstanding", $realtime);
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_data.hit != want.hit) report_mismatch("hit", rsp_data.hit, want.hit);
               if (rsp_data.score_out != want.score_out)
                  report_mismatch("score_out", rsp_data.score_out, want.score_out);
               if (rsp_data.eval_out != want.eval_out)
                  report_mismatch("eval_out", rsp_data.eval_out, want.eval_out);
               if (rsp_data.move_out != want.move_out)
                  report_mismatch("move_out", rsp_data.move_out, want.move_out);
               if (rsp_data.entry_flags != want.entry_flags)
                  report_mismatch("entry_flags", rsp_data.entry_flags, want.entry_flags);
               if (rsp_data.fill_count != want.fill_count)
                  report_mismatch("fill_count", rsp_data.fill_count, want.fill_count);
            end
         end
         if (req_valid && req_ready) predict_answer(req_data);
      end
   end

endmodule

`default_nettype wire

// ===== dv/bucketed_transposition_table_unit_tb.sv =====
// Testbench top for the bucketed transposition table unit: clock, reset,
// request and register stimulus, response back-pressure and the verdict.
// Depends on btt_pkg, the unit itself and btt_scoreboard.
`default_nettype none

module bucketed_transposition_table_unit_tb;
   import btt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 600000;
   localparam int PhaseItems = 205;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   btt_req_type             req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   btt_rsp_type             rsp_data;
   logic                    csr_we;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;
   int                      errors;
   int                      pending;

   int                      sent_count;
   int                      done_count;
   int                      cycles;
   int                      send_idle_pct;
   int                      recv_stall_pct;
   int                      hold_token;
   int                      hold_seen;
   int                      hold_left;
   logic [31:0]             cur_no_move;
   logic [63:0]             key_hi_pool[4];
   logic [9:0]              bucket_pool[4];

   bucketed_transposition_table_unit dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   btt_scoreboard scoreboard (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata, .errors, .pending
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Transfer counters and the run limit.
   always @(posedge clock) begin
      if (reset) begin
         sent_count <= 0;
         done_count <= 0;
      end else begin
         if (req_valid && req_ready) sent_count <= sent_count + 1;
         if (rsp_valid && rsp_ready) done_count <= done_count + 1;
      end
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("bucketed_transposition_table_unit_tb NOT OK");
         $finish;
      end
   end

   // Response back-pressure, with a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one request and waits for its transfer. Valid stays up after the
   // transfer so that a following request can go out back to back; the
   // next idle cycle or wait_drained takes it down.
   task automatic send_request(input btt_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (done_count != sent_count || req_valid) @(posedge clock);
   endtask

   // One register write; the enable drops again before the next write.
   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic btt_req_type make_req(input logic [1:0] kind, input logic [63:0] key,
                                            input int depth, input int score,
                                            input logic [1:0] bound, input logic [31:0] mv);
      btt_req_type r;
      r.kind         = kind;
      r.key          = key;
      r.ply          = 7'($urandom_range(127));
      r.search_depth = 8'(depth);
      r.score_in     = 16'(score);
      r.eval_in      = 16'($urandom);
      r.bound_in     = bound;
      r.move_in      = mv;
      return r;
   endfunction

   // Random request aimed at a few crowded buckets most of the time.
   function automatic btt_req_type random_req();
      btt_req_type r;
      int          pick;
      logic [63:0] key;
      pick = $urandom_range(99);
      if (pick < 10) key = {$urandom, $urandom};
      else if (pick < 12) key = '0;
      else key = {key_hi_pool[$urandom_range(3)][63:10], bucket_pool[$urandom_range(3)]};
      r = make_req(KIND_STORE, key, $urandom_range(70) - 3, 0, 2'($urandom_range(3)),
                   ($urandom_range(4) == 0) ? cur_no_move : $urandom);
      pick = $urandom_range(99);
      r.kind = (pick < 45) ? KIND_PROBE : (pick < 98) ? KIND_STORE : 2'd3;
      if ($urandom_range(9) == 0) r.search_depth = 8'($urandom);
      pick = $urandom_range(3);
      if (pick == 0) r.score_in = 16'($urandom);
      else if (pick == 1) r.score_in = 16'(32767 - $urandom_range(200));
      else if (pick == 2) r.score_in = 16'(-32768 + $urandom_range(200));
      else r.score_in = 16'($urandom_range(600) - 300);
      return r;
   endfunction

   initial begin
      logic [63:0] k;
      int          phase_age;
      logic [14:0] phase_mate;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      cycles         = 0;
      hold_token     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cur_no_move    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, one crowded bucket, depth guard, mate scores, depth clamp, unused kind, clear.
      k = 64'h0123_4567_89AB_C155;
      send_request(make_req(KIND_PROBE, '0, 0, 0, 2'd0, 32'h0));
      send_request(make_req(KIND_STORE, '0, 5, 100, 2'd1, 32'h1111));
      send_request(make_req(KIND_PROBE, '0, 0, 0, 2'd0, 32'h0));
      for (int i = 1; i <= 5; i++)
         send_request(make_req(KIND_STORE, k + 64'(i) * 64'h400, 10 + i, i, 2'd2, 32'(i)));
      for (int i = 1; i <= 5; i++)
         send_request(make_req(KIND_PROBE, k + 64'(i) * 64'h400, 0, 0, 2'd0, 32'h0));
      send_request(make_req(KIND_STORE, k + 64'h400, 2, 7, 2'd3, 32'h0));
      send_request(make_req(KIND_STORE, k + 64'h400, 60, 32767, 2'd3, 32'h0));
      send_request(make_req(KIND_PROBE, k + 64'h400, 0, 0, 2'd0, 32'h0));
      send_request(make_req(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 127, -32768, 2'd1,
                            32'hFFFF_FFFF));
      send_request(make_req(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF, -128, 30000, 2'd0, 32'h0));
      send_request(make_req(KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 2'd0, 32'h0));
      send_request(make_req(2'd3, k, 0, 0, 2'd0, 32'h0));
      send_request(make_req(KIND_CLEAR, '0, 0, 0, 2'd0, 32'h0));
      send_request(make_req(KIND_PROBE, k + 64'h400, 0, 0, 2'd0, 32'h0));

      // Random phases, each with its own registers and idling pattern.
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         for (int i = 0; i < 4; i++) begin
            key_hi_pool[i] = {$urandom, $urandom};
            bucket_pool[i] = 10'($urandom);
         end
         bucket_pool[0] = (phase % 2) ? 10'h3FF : 10'h000;
         phase_age  = (phase == 1) ? 127 : (phase == 2) ? 0 : $urandom_range(127);
         phase_mate = (phase == 3) ? 15'd0 : (phase == 4) ? 15'h7FFF :
                      (phase == 5) ? 15'd30000 : 15'($urandom_range(32767));
         cur_no_move = (phase == 2) ? 32'hFFFF_FFFF : (phase < 2) ? 32'h0 : $urandom;
         write_csr(CSR_CURRENT_AGE, 32'(phase_age));
         write_csr(CSR_MATE_BOUND, 32'(phase_mate));
         write_csr(CSR_NO_MOVE_CODE, cur_no_move);
         send_idle_pct  = (phase % 4 == 1) ? 68 : (phase % 4 == 3) ? 18 : 0;
         recv_stall_pct = (phase % 4 == 2) ? 68 : (phase % 4 == 3) ? 18 : 0;
         for (int i = 0; i < PhaseItems; i++) begin
            if (i == 40 && phase == 1) hold_token <= hold_token + 1;
            if (i == 100 && phase == 2) wait_drained();
            if (i == 150) begin
               // Older entries go stale when the age moves on.
               wait_drained();
               write_csr(CSR_CURRENT_AGE, 32'($urandom_range(127)));
            end
            send_request((i == PhaseItems - 1 && phase % 3 == 0) ?
                         make_req(KIND_CLEAR, {$urandom, $urandom}, 0, 0, 2'd0, 32'h0) :
                         random_req());
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("bucketed_transposition_table_unit_tb OK");
      end else begin
         $display("bucketed_transposition_table_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== bucketed_transposition_table_unit.f =====
rtl/core/btt_pkg.sv
rtl/core/btt_ram.sv
rtl/core/btt_ctrl.sv
rtl/core/btt_datapath.sv
rtl/core/bucketed_transposition_table_unit.sv
dv/btt_scoreboard.sv
dv/bucketed_transposition_table_unit_tb.sv
